// ===== rtl/core/text_field_unescape_utf8_check_top_assert.svh =====
// Assertion macros for the field unescape / UTF-8 check block.
`ifndef TEXT_FIELD_UNESCAPE_UTF8_CHECK_TOP_ASSERT_SVH
`define TEXT_FIELD_UNESCAPE_UTF8_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define TFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tfu_pkg.sv =====
package tfu_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CapW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // Result queue depth (must hold two results of one item)
  localparam int unsigned OutqDepthDef = 4;

  // Register reset values
  localparam logic [CapW-1:0] CapReset = 16'd1024;

  // Character codes
  localparam logic [ByteW-1:0] BsChar    = 8'h5C;
  localparam logic [ByteW-1:0] NChar     = 8'h6E;
  localparam logic [ByteW-1:0] NlChar    = 8'h0A;
  localparam logic [ByteW-1:0] TabChar   = 8'h09;
  localparam logic [ByteW-1:0] CtrlLimit = 8'h20;

  // Code point limits
  localparam logic [20:0] Min2  = 21'h00080;
  localparam logic [20:0] Min3  = 21'h00800;
  localparam logic [20:0] Min4  = 21'h10000;
  localparam logic [20:0] MaxCp = 21'h10FFFF;
  localparam logic [20:0] SurLo = 21'h0D800;
  localparam logic [20:0] SurHi = 21'h0DFFF;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDecode   = 1'b0,
    CfgCapacity = 1'b1
  } cfg_idx_e;

  // Field status codes
  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StEmpty   = 2'd1,
    StTooLong = 2'd2,
    StInvalid = 2'd3
  } status_e;

  // UTF-8 checker state
  typedef struct packed {
    logic [1:0]  cont;
    logic [2:0]  seq;
    logic [20:0] acc;
    logic        bad;
  } utf_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_present;
    logic             last;
    status_e          status;
  } res_t;

  // Push of up to two results into the result queue
  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t res0;
    res_t res1;
  } qpush_t;

  // Advance the UTF-8 checker by one accepted byte
  function automatic utf_t utf8_step(utf_t s, logic [ByteW-1:0] b);
    utf_t        r;
    logic [20:0] acc_n;
    r     = s;
    acc_n = {s.acc[14:0], b[5:0]};
    if (s.cont == 2'd0) begin
      if (!b[7]) begin
        if (b < CtrlLimit && b != TabChar && b != NlChar) r.bad = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        r.seq = 3'd2; r.cont = 2'd1; r.acc = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        r.seq = 3'd3; r.cont = 2'd2; r.acc = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        r.seq = 3'd4; r.cont = 2'd3; r.acc = {18'd0, b[2:0]};
      end else begin
        r.bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: restart at a lead byte
      r.bad  = 1'b1;
      r.cont = 2'd0;
      r.seq  = 3'd0;
      r.acc  = '0;
    end else begin
      r.acc  = acc_n;
      r.cont = s.cont - 2'd1;
      if (s.cont == 2'd1) begin
        // sequence complete: overlong, range and surrogate checks
        if ((s.seq == 3'd2 && acc_n < Min2) ||
            (s.seq == 3'd3 && acc_n < Min3) ||
            (s.seq == 3'd4 && (acc_n < Min4 || acc_n > MaxCp)) ||
            (acc_n >= SurLo && acc_n <= SurHi)) begin
          r.bad = 1'b1;
        end
        r.seq = 3'd0;
        r.acc = '0;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tfu_if.sv =====
// Source field byte channel
interface tfu_in_if;
  logic                        valid;
  logic                        ready;
  logic [tfu_pkg::ByteW-1:0]   in_byte;
  logic                        byte_present;
  logic                        field_end;

  modport source (output valid, in_byte, byte_present, field_end, input ready);
  modport sink   (input valid, in_byte, byte_present, field_end, output ready);
endinterface

// Decoded result channel
interface tfu_out_if;
  logic                        valid;
  logic                        ready;
  logic [tfu_pkg::ByteW-1:0]   out_byte;
  logic                        out_present;
  logic                        last;
  logic [tfu_pkg::StatusW-1:0] status;

  modport source (output valid, out_byte, out_present, last, status, input ready);
  modport sink   (input valid, out_byte, out_present, last, status, output ready);
endinterface

// Register write channel
interface tfu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tfu_pkg::CfgIdxW-1:0]  idx;
  logic [tfu_pkg::CfgDataW-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/core/text_field_unescape_utf8_check_top.sv =====
// Channel | Dir | Handshake   | Payload
// in_i    | in  | valid/ready | in_byte[8], byte_present, field_end
// out_o   | out | valid/ready | out_byte[8], out_present, last, status[2]
// cfg_i   | in  | valid/ready | idx[1], data[16] (ready always high)
//
// An item is registered, then decoded and checked from the input register,
// and its zero to two results enter a result queue. One item per cycle is
// sustained while items give at most one result each and the receiver does
// not stall; the queue's single read port limits output to one result per
// cycle. Reset is asynchronous and clears all but the data registers. A
// stalled output only holds off input once the queue has no room for two.
module text_field_unescape_utf8_check_top #(
  parameter int unsigned OutqDepth = tfu_pkg::OutqDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfu_in_if.sink    in_i,
  tfu_out_if.source out_o,
  tfu_cfg_if.sink   cfg_i
);

  // configuration registers
  logic                        dec_q;
  logic [tfu_pkg::CapW-1:0]    cap_q;

  // input register
  logic                        in_vld_q;
  logic [tfu_pkg::ByteW-1:0]   byte_q;
  logic                        present_q, end_q;

  // per-field state
  logic                        pend_q, pend_d;
  logic [tfu_pkg::CapW-1:0]    bw_q, bw_d;
  logic                        ovf_q, ovf_d;
  tfu_pkg::utf_t               utf_q, utf_d;

  logic                        adv, space2;
  tfu_pkg::qpush_t             push;
  tfu_pkg::res_t               res;

  // decode and check signals
  logic                        dec_bs, pend_mid;
  logic                        s0_v, s1_v, e0, e1;
  logic [tfu_pkg::ByteW-1:0]   s0_b, s1_b;
  logic [tfu_pkg::CapW-1:0]    bw1;
  logic                        ovf1;
  tfu_pkg::utf_t               u1;
  tfu_pkg::status_e            st;

  assign adv         = in_vld_q && space2;
  assign in_i.ready  = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= 1'b0;
      cap_q <= tfu_pkg::CapReset;
    end else if (cfg_i.valid) begin
      unique case (tfu_pkg::cfg_idx_e'(cfg_i.idx))
        tfu_pkg::CfgDecode:   dec_q <= cfg_i.data[0];
        tfu_pkg::CfgCapacity: cap_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q    <= in_i.in_byte;
      present_q <= in_i.byte_present;
      end_q     <= in_i.field_end;
    end
  end

  // escape decoding: up to two candidate bytes
  always_comb begin
    dec_bs   = dec_q && (byte_q == tfu_pkg::BsChar);
    s0_v     = 1'b0;
    s0_b     = '0;
    s1_v     = 1'b0;
    s1_b     = '0;
    pend_mid = pend_q;
    if (present_q) begin
      if (pend_q) begin
        pend_mid = 1'b0;
        s0_v     = 1'b1;
        if (byte_q == tfu_pkg::NChar) begin
          s0_b = tfu_pkg::NlChar;
        end else begin
          s0_b = tfu_pkg::BsChar;
          if (dec_bs) begin
            pend_mid = 1'b1;
          end else begin
            s1_v = 1'b1;
            s1_b = byte_q;
          end
        end
      end else if (dec_bs) begin
        pend_mid = 1'b1;
      end else begin
        s0_v = 1'b1;
        s0_b = byte_q;
      end
    end
    // flush a pending backslash at the field end
    if (end_q && pend_mid) begin
      pend_mid = 1'b0;
      if (s0_v) begin
        s1_v = 1'b1;
        s1_b = tfu_pkg::BsChar;
      end else begin
        s0_v = 1'b1;
        s0_b = tfu_pkg::BsChar;
      end
    end
  end

  // capacity gate and UTF-8 check, one candidate after the other
  always_comb begin
    e0   = 1'b0;
    bw1  = bw_q;
    ovf1 = ovf_q;
    u1   = utf_q;
    if (s0_v) begin
      if (({1'b0, bw_q} + 17'd1) < {1'b0, cap_q}) begin
        e0  = 1'b1;
        bw1 = bw_q + 16'd1;
        u1  = tfu_pkg::utf8_step(utf_q, s0_b);
      end else begin
        ovf1 = 1'b1;
      end
    end
    e1    = 1'b0;
    bw_d  = bw1;
    ovf_d = ovf1;
    utf_d = u1;
    if (s1_v) begin
      if (({1'b0, bw1} + 17'd1) < {1'b0, cap_q}) begin
        e1    = 1'b1;
        bw_d  = bw1 + 16'd1;
        utf_d = tfu_pkg::utf8_step(u1, s1_b);
      end else begin
        ovf_d = 1'b1;
      end
    end
    pend_d = pend_mid;
  end

  // field status, too_long first
  always_comb begin
    if (ovf_d)                                st = tfu_pkg::StTooLong;
    else if (bw_d == '0)                      st = tfu_pkg::StEmpty;
    else if (utf_d.bad || utf_d.cont != 2'd0) st = tfu_pkg::StInvalid;
    else                                      st = tfu_pkg::StOk;
  end

  // results into the queue; last and status ride on the final one
  always_comb begin
    push.vld0 = adv && (e0 || e1 || end_q);
    push.vld1 = adv && e0 && e1;
    push.res0.out_byte    = e0 ? s0_b : (e1 ? s1_b : '0);
    push.res0.out_present = e0 || e1;
    push.res0.last        = end_q && !(e0 && e1);
    push.res0.status      = push.res0.last ? st : tfu_pkg::StOk;
    push.res1.out_byte    = s1_b;
    push.res1.out_present = 1'b1;
    push.res1.last        = end_q;
    push.res1.status      = end_q ? st : tfu_pkg::StOk;
  end

  // per-field state, cleared at the field end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      bw_q   <= '0;
      ovf_q  <= 1'b0;
      utf_q  <= '0;
    end else if (adv) begin
      if (end_q) begin
        pend_q <= 1'b0;
        bw_q   <= '0;
        ovf_q  <= 1'b0;
        utf_q  <= '0;
      end else begin
        pend_q <= pend_d;
        bw_q   <= bw_d;
        ovf_q  <= ovf_d;
        utf_q  <= utf_d;
      end
    end
  end

  tfu_outq #(
    .Depth (OutqDepth)
  ) u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (space2),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .res_o    (res)
  );

  assign out_o.out_byte    = res.out_byte;
  assign out_o.out_present = res.out_present;
  assign out_o.last        = res.last;
  assign out_o.status      = res.status;

endmodule

// ===== rtl/core/tfu_outq.sv =====
// Result queue: takes up to two results per cycle, gives one per ready cycle
module tfu_outq #(
  parameter int unsigned Depth = tfu_pkg::OutqDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tfu_pkg::qpush_t push_i,
  output logic            space2_o,
  output logic            valid_o,
  input  logic            ready_i,
  output tfu_pkg::res_t   res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntSpace2 = CntW'(Depth - 2);

  tfu_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, wptr_inc, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign wptr_inc = ptr_next(wptr_q);
  assign pop      = valid_o && ready_i;
  assign valid_o  = (cnt_q != '0);
  assign space2_o = (cnt_q <= CntSpace2);
  assign res_o    = mem_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    if (push_i.vld1)      wptr_d = ptr_next(wptr_inc);
    else if (push_i.vld0) wptr_d = wptr_inc;
    rptr_d = pop ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i.vld0) + CntW'(push_i.vld1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.vld0) mem_q[wptr_q]   <= push_i.res0;
    if (push_i.vld1) mem_q[wptr_inc] <= push_i.res1;
  end

endmodule

// ===== rtl/core/tfu_check.sv =====
`include "text_field_unescape_utf8_check_top_assert.svh"

// Port-level checks of the result channel
module tfu_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tfu_pkg::ByteW-1:0]   out_byte_i,
  input logic                        out_present_i,
  input logic                        last_i,
  input logic [tfu_pkg::StatusW-1:0] status_i
);

  // terse views of the result channel
  logic                        hold;
  logic [tfu_pkg::ByteW+3:0]   pl;
  logic                        mid_res;
  logic                        st_ok;
  logic                        bare_res;
  logic                        byte_zero;
  logic                        empty_end;

  assign hold      = out_valid_i && !out_ready_i;
  assign pl        = {out_byte_i, out_present_i, last_i, status_i};
  assign mid_res   = out_valid_i && !last_i;
  assign st_ok     = (status_i == tfu_pkg::StOk);
  assign bare_res  = out_valid_i && !out_present_i;
  assign byte_zero = (out_byte_i == '0);
  assign empty_end = out_valid_i && last_i && (status_i == tfu_pkg::StEmpty);

  // a stalled result holds
  `TFU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, hold, out_valid_i && $stable(pl), "held item changed")

  // status only on the final result of a field; earlier results carry a byte
  `TFU_ASSERT_IMP(a_status_last, clk_i, rst_ni, mid_res, st_ok && out_present_i, "early status")

  // a bare result carries no byte
  `TFU_ASSERT_IMP(a_bare_zero, clk_i, rst_ni, bare_res, byte_zero && last_i, "bare byte set")

  // an empty field never ends on a byte
  `TFU_ASSERT_IMP(a_empty_bare, clk_i, rst_ni, empty_end, !out_present_i, "empty status on a byte")

endmodule

bind text_field_unescape_utf8_check_top tfu_check u_tfu_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_present_i (out_o.out_present),
  .last_i        (out_o.last),
  .status_i      (out_o.status)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni;

  tfu_in_if  in_if ();
  tfu_out_if out_if ();
  tfu_cfg_if cfg_if ();

  text_field_unescape_utf8_check_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Decoder copy: registers
  logic        esc_on;
  logic [15:0] cap;
  // Decoder copy: per-field state
  logic        bs_held;
  logic [15:0] n_stored;
  logic [1:0]  cont_left;
  logic [2:0]  seq_len;
  logic [20:0] cp_acc;
  logic        overflowed;
  logic        text_bad;

  // Results of the item being decoded, then the results still owed
  tfu_pkg::res_t item_res [3];
  int            item_n;
  tfu_pkg::res_t decoded_q [$];
  tfu_pkg::res_t oldest;

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 4;
  int unsigned stall_step = 0;
  logic [7:0] field_bytes [$];

  function automatic void clear_field_state();
    bs_held    = 1'b0;
    n_stored   = '0;
    cont_left  = '0;
    seq_len    = '0;
    cp_acc     = '0;
    overflowed = 1'b0;
    text_bad   = 1'b0;
  endfunction

  // UTF-8 tracking over the bytes that made it into the destination
  function automatic void track_utf8(logic [7:0] b);
    logic [20:0] next_cp;
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        if (b < 8'h20 && b != tfu_pkg::TabChar && b != tfu_pkg::NlChar) text_bad = 1'b1;
      end else if ((b & 8'hE0) == 8'hC0) begin
        seq_len = 3'd2; cont_left = 2'd1; cp_acc = 21'(b[4:0]);
      end else if ((b & 8'hF0) == 8'hE0) begin
        seq_len = 3'd3; cont_left = 2'd2; cp_acc = 21'(b[3:0]);
      end else if ((b & 8'hF8) == 8'hF0) begin
        seq_len = 3'd4; cont_left = 2'd3; cp_acc = 21'(b[2:0]);
      end else begin
        text_bad = 1'b1;
      end
    end else if ((b & 8'hC0) != 8'h80) begin
      // sequence broken: start over at a lead byte
      text_bad  = 1'b1;
      cont_left = '0;
      seq_len   = '0;
      cp_acc    = '0;
    end else begin
      next_cp   = {cp_acc[14:0], b[5:0]};
      cp_acc    = next_cp;
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if ((seq_len == 3'd2 && next_cp < 21'h80) ||
            (seq_len == 3'd3 && next_cp < 21'h800) ||
            (seq_len == 3'd4 && (next_cp < 21'h10000 || next_cp > 21'h10FFFF)) ||
            (next_cp >= 21'hD800 && next_cp <= 21'hDFFF))
          text_bad = 1'b1;
        seq_len = '0;
        cp_acc  = '0;
      end
    end
  endfunction

  // Write one byte to the destination if it still fits (one slot kept for the terminator)
  function automatic void store_byte(logic [7:0] b);
    if (int'(n_stored) + 1 >= int'(cap)) begin
      overflowed = 1'b1;
    end else begin
      n_stored = n_stored + 16'd1;
      track_utf8(b);
      item_res[item_n] = '{out_byte: b, out_present: 1'b1, last: 1'b0,
                           status: tfu_pkg::StOk};
      item_n++;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (esc_on && b == tfu_pkg::BsChar) bs_held = 1'b1;
    else store_byte(b);
  endfunction

  // Work out the results of one accepted item and queue them
  function automatic void decode_item(logic [7:0] b, logic present, logic fend);
    tfu_pkg::status_e st;
    item_n = 0;
    if (present) begin
      if (bs_held) begin
        bs_held = 1'b0;
        if (b == tfu_pkg::NChar) begin
          store_byte(tfu_pkg::NlChar);
        end else begin
          store_byte(tfu_pkg::BsChar);
          take_byte(b);
        end
      end else begin
        take_byte(b);
      end
    end
    if (fend) begin
      if (bs_held) begin
        bs_held = 1'b0;
        store_byte(tfu_pkg::BsChar);
      end
      if (overflowed) st = tfu_pkg::StTooLong;
      else if (n_stored == 16'd0) st = tfu_pkg::StEmpty;
      else if (text_bad || cont_left != 2'd0) st = tfu_pkg::StInvalid;
      else st = tfu_pkg::StOk;
      if (item_n == 0) begin
        item_res[0] = '{out_byte: 8'h00, out_present: 1'b0, last: 1'b0,
                        status: tfu_pkg::StOk};
        item_n = 1;
      end
      item_res[item_n-1].last   = 1'b1;
      item_res[item_n-1].status = st;
      clear_field_state();
    end
    for (int i = 0; i < item_n; i++) decoded_q.push_back(item_res[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Send one item; bursts of random length with random gaps after them
  task automatic send_item(logic [7:0] b, logic present, logic fend);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.byte_present <= present;
    in_if.field_end    <= fend;
    do @(posedge clk_i); while (!in_if.ready);
    decode_item(b, present, fend);
    if (present || fend) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 80)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic write_reg(tfu_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      tfu_pkg::CfgDecode:   esc_on = data[0];
      tfu_pkg::CfgCapacity: cap = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, let every owed result arrive, then allow for items still in flight
  task automatic finish_phase();
    if (in_if.valid) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Encode a code point with a forced sequence length (overlong when too long)
  function automatic void append_code(int cp, int n);
    case (n)
      1: field_bytes.push_back(8'(cp & 'h7F));
      2: begin
        field_bytes.push_back(8'hC0 | 8'((cp >> 6) & 'h1F));
        field_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end
      3: begin
        field_bytes.push_back(8'hE0 | 8'((cp >> 12) & 'h0F));
        field_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
        field_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end
      default: begin
        field_bytes.push_back(8'hF0 | 8'((cp >> 18) & 'h07));
        field_bytes.push_back(8'h80 | 8'((cp >> 12) & 'h3F));
        field_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
        field_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end
    endcase
  endfunction

  // Legal code point for a given sequence length
  function automatic int legal_cp(int n);
    int cp;
    case (n)
      2: cp = $urandom_range('h80, 'h7FF);
      3: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  // Mostly well-formed text with escapes, some broken UTF-8 and noise
  function automatic void append_char();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 34) begin
      field_bytes.push_back(8'($urandom_range('h20, 'h7E)));
    end else if (pick < 39) begin
      field_bytes.push_back($urandom_range(0, 1) ? tfu_pkg::TabChar : tfu_pkg::NlChar);
    end else if (pick < 49) begin
      field_bytes.push_back(tfu_pkg::BsChar);
      field_bytes.push_back(tfu_pkg::NChar);
    end else if (pick < 55) begin
      field_bytes.push_back(tfu_pkg::BsChar);
      field_bytes.push_back($urandom_range(0, 2) == 0 ? tfu_pkg::BsChar
                            : 8'($urandom_range('h20, 'h7E)));
    end else if (pick < 78) begin
      n = $urandom_range(2, 4);
      append_code(legal_cp(n), n);
    end else if (pick < 82) begin
      // overlong
      n = $urandom_range(2, 4);
      append_code($urandom_range(0, n == 2 ? 'h7F : n == 3 ? 'h7FF : 'hFFFF), n);
    end else if (pick < 85) begin
      append_code($urandom_range('hD800, 'hDFFF), 3);
    end else if (pick < 88) begin
      // above the last code point
      append_code($urandom_range('h110000, 'h1FFFFF), 4);
    end else if (pick < 92) begin
      // truncated sequence
      n = $urandom_range(2, 4);
      append_code(legal_cp(n), n);
      field_bytes.delete(field_bytes.size() - 1);
    end else if (pick < 97) begin
      field_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      field_bytes.push_back(8'($urandom_range(0, 'h1F)));
    end
  endfunction

  task automatic send_random_field();
    int   chars;
    logic bare_end;
    field_bytes.delete();
    chars = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
    repeat (chars) append_char();
    bare_end = (field_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (field_bytes[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(field_bytes[i], 1'b1, !bare_end && i == field_bytes.size() - 1);
    end
    if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Empty field, ignored bare item, plain text at reset settings
  task automatic test_empty_and_plain();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(tfu_pkg::TabChar, 1'b1, 1'b1);
    finish_phase();
  endtask

  // Escape pairs, held backslash, flush at field end
  task automatic test_escape_pairs();
    write_reg(tfu_pkg::CfgDecode, 16'd1);
    send_item(tfu_pkg::BsChar, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);   // bare item keeps the backslash held
    send_item(tfu_pkg::NChar, 1'b1, 1'b0);
    send_item(tfu_pkg::BsChar, 1'b1, 1'b0);
    send_item(8'h78, 1'b1, 1'b0);   // not an escape: two bytes out
    send_item(tfu_pkg::BsChar, 1'b1, 1'b0);
    send_item(tfu_pkg::BsChar, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);   // held backslash flushed at end
    finish_phase();
    // held backslash survives a register write and is decided later
    send_item(tfu_pkg::BsChar, 1'b1, 1'b0);
    finish_phase();
    write_reg(tfu_pkg::CfgDecode, 16'd0);
    send_item(tfu_pkg::NChar, 1'b1, 1'b1);
    finish_phase();
  endtask

  // Highest code point, truncated, surrogate, stray continuation, control byte
  task automatic test_utf8_edges();
    send_item(8'hF4, 1'b1, 1'b0);
    send_item(8'h8F, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b1);
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b1);
    send_item(8'hED, 1'b1, 1'b0);
    send_item(8'hA0, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h01, 1'b1, 1'b1);
    finish_phase();
  endtask

  // Smallest capacities: nothing fits
  task automatic test_capacity_limits();
    write_reg(tfu_pkg::CfgCapacity, 16'd1);
    send_item(8'h61, 1'b1, 1'b1);
    finish_phase();
    write_reg(tfu_pkg::CfgCapacity, 16'd0);
    send_item(8'h62, 1'b1, 1'b1);
    finish_phase();
  endtask

  // Random fields over many register settings
  task automatic test_random_fields();
    int          phase_end;
    logic [15:0] new_cap;
    logic [15:0] new_esc;
    while (items_sent < 1300) begin
      case ($urandom_range(0, 9))
        0:       new_cap = 16'd1;
        1:       new_cap = 16'd0;
        2:       new_cap = 16'hFFFF;
        3:       new_cap = 16'd1024;
        4, 5, 6: new_cap = 16'($urandom_range(2, 8));
        default: new_cap = 16'($urandom_range(9, 40));
      endcase
      new_esc = 16'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        write_reg(tfu_pkg::CfgDecode, new_esc);
        write_reg(tfu_pkg::CfgCapacity, new_cap);
      end else begin
        write_reg(tfu_pkg::CfgCapacity, new_cap);
        write_reg(tfu_pkg::CfgDecode, new_esc);
      end
      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) send_random_field();
      finish_phase();
    end
  endtask

  // Receiver: its own stall pattern, chosen by bits 7:6 of a step counter
  always @(posedge clk_i) begin
    stall_step <= stall_step + 1;
    case (stall_step[7:6])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_if.ready <= (stall_step[2:0] > 3'd4);
      default: out_if.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing owed, out_byte", int'(out_if.out_byte), 0);
      end else begin
        oldest = decoded_q.pop_front();
        if (out_if.out_byte !== oldest.out_byte)
          report_mismatch("out_byte", int'(out_if.out_byte), int'(oldest.out_byte));
        if (out_if.out_present !== oldest.out_present)
          report_mismatch("out_present", int'(out_if.out_present), int'(oldest.out_present));
        if (out_if.last !== oldest.last)
          report_mismatch("last", int'(out_if.last), int'(oldest.last));
        if (out_if.status !== oldest.status)
          report_mismatch("status", int'(out_if.status), int'(oldest.status));
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= '0;
    in_if.byte_present <= 1'b0;
    in_if.field_end    <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.idx         <= tfu_pkg::CfgDecode;
    cfg_if.data        <= '0;
    // register values after reset
    esc_on = 1'b0;
    cap    = 16'd1024;
    clear_field_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_plain();
    test_escape_pairs();
    test_utf8_edges();
    test_capacity_limits();
    test_random_fields();
    finish_phase();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
